FILE: design/cghp_pkg.sv
// Shared types, codes and constants of the CGI header line parser.
package cghp_pkg;

    localparam int COUNT_BITS     = 8;
    localparam int LINE_BITS      = 12;
    localparam int STATUS_BITS    = 16;
    localparam int COUNT_EXT_BITS = 16;

    localparam logic [LINE_BITS-1:0]   LINE_LEN_RESET = 12'd512;
    localparam logic [LINE_BITS-1:0]   LINE_MAX_COUNT = 12'hFFF;
    localparam logic [STATUS_BITS-1:0] STATUS_MAX     = 16'hFFFF;

    localparam logic [0:0] CFG_LOWER_CASE_NAMES = 1'b0;
    localparam logic [0:0] CFG_MAX_LINE_LEN     = 1'b1;

    localparam logic [2:0] KIND_NONE     = 3'd0;
    localparam logic [2:0] KIND_NAME     = 3'd1;
    localparam logic [2:0] KIND_VALUE    = 3'd2;
    localparam logic [2:0] KIND_HDR_DONE = 3'd3;
    localparam logic [2:0] KIND_HDRS_END = 3'd4;
    localparam logic [2:0] KIND_ERROR    = 3'd5;
    localparam logic [2:0] KIND_BODY     = 3'd6;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_LINE_LONG = 3'd1;
    localparam logic [2:0] ERR_NAME_BRK  = 3'd2;
    localparam logic [2:0] ERR_CR_NO_LF  = 3'd3;
    localparam logic [2:0] ERR_NUL       = 3'd4;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_UP_S  = 8'h53;
    localparam logic [7:0] CASE_GAP = 8'h20;

    localparam logic [2:0] STATUS_LEN = 3'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_response;
    } t_in_item;

    typedef struct packed {
        logic                 lower_case_names;
        logic [LINE_BITS-1:0] max_line_len;
    } t_cfg;

    typedef struct packed {
        logic                   open;
        logic                   seen;
        logic [STATUS_BITS-1:0] work;
    } t_digit_state;

    typedef struct packed {
        logic [2:0]             byte_kind;
        logic [7:0]             out_byte;
        logic [2:0]             error_code;
        logic [7:0]             header_count;
        logic [STATUS_BITS-1:0] status_code;
        logic                   status_seen;
    } t_result;

    // Lower-case letters of the word "status", indexed by match position.
    function automatic logic [7:0] status_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h73;
            3'd1:    c = 8'h74;
            3'd2:    c = 8'h61;
            3'd3:    c = 8'h74;
            3'd4:    c = 8'h75;
            3'd5:    c = 8'h73;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: design/cghp_in_if.sv
// Input channel interface: one stream byte with its start flag.
interface cghp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_response;

    modport source (output valid, output data_byte, output start_of_response, input ready);
    modport sink (input valid, input data_byte, input start_of_response, output ready);
endinterface

FILE: design/cghp_out_if.sv
// Output channel interface: one classified byte with the parser status.
interface cghp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  byte_kind;
    logic [7:0]  out_byte;
    logic [2:0]  error_code;
    logic [7:0]  header_count;
    logic [15:0] status_code;
    logic        status_seen;

    modport source (output valid, output byte_kind, output out_byte, output error_code,
                    output header_count, output status_code, output status_seen,
                    input ready);
    modport sink (input valid, input byte_kind, input out_byte, input error_code,
                  input header_count, input status_code, input status_seen,
                  output ready);
endinterface

FILE: design/cghp_in_stage.sv
// Input register that holds one accepted word until the parser takes it.
module cghp_in_stage
    import cghp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  logic     i_advance,
    input  t_in_item i_item,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;

    always_comb begin
        n_valid = r_valid;
        if (i_accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: design/cghp_status_digits.sv
// Decimal accumulation of the status header value, one character at a time.
module cghp_status_digits
    import cghp_pkg::*;
(
    input  logic [7:0]   i_char,
    input  t_digit_state i_cur,
    output t_digit_state o_next
);

    logic                   is_digit;
    logic                   is_blank;
    logic [19:0]            sum;

    assign is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign is_blank = (i_char == CH_SPACE) || (i_char == CH_TAB) ||
                      (i_char == CH_VT) || (i_char == CH_FF);
    assign sum = ({4'd0, i_cur.work} << 3) + ({4'd0, i_cur.work} << 1) +
                 {16'd0, i_char[3:0]};

    always_comb begin
        o_next = i_cur;
        if (i_cur.open) begin
            if (is_digit) begin
                o_next.work = (sum > {4'd0, STATUS_MAX}) ? STATUS_MAX : sum[STATUS_BITS-1:0];
                o_next.seen = 1'b1;
            end else if (!(is_blank && !i_cur.seen)) begin
                o_next.open = 1'b0;
            end
        end
    end

endmodule

FILE: design/cghp_parser.sv
// Parser state, per-byte classification and the result register.
module cghp_parser
    import cghp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_advance,
    input  t_in_item i_item,
    input  t_cfg     i_cfg,
    output t_result  o_result
);

    localparam logic [2:0] PH_NAME   = 3'd0;
    localparam logic [2:0] PH_VALUE  = 3'd1;
    localparam logic [2:0] PH_CRWAIT = 3'd2;
    localparam logic [2:0] PH_BODY   = 3'd3;
    localparam logic [2:0] PH_ERROR  = 3'd4;

    logic [2:0]            r_phase, n_phase, c_phase;
    logic [LINE_BITS-1:0]  r_line, n_line, c_line;
    logic                  r_name_ne, n_name_ne, c_name_ne;
    logic                  r_value_ne, n_value_ne, c_value_ne;
    logic [2:0]            r_match_pos, n_match_pos, c_match_pos;
    logic                  r_mismatch, n_mismatch, c_mismatch;
    t_digit_state          r_digits, n_digits, c_digits, trk_digits;
    logic [STATUS_BITS-1:0] r_status_acc, n_status_acc, c_status_acc;
    logic                  r_status_flag, n_status_flag, c_status_flag;
    logic [COUNT_BITS-1:0] r_headers, n_headers, c_headers;
    logic [2:0]            r_error, n_error, c_error;
    t_result               r_result, n_result;

    logic [7:0]            ch;
    logic [7:0]            name_ch;
    logic [2:0]            kind;
    logic [7:0]            emit;
    logic                  sor;
    logic [COUNT_EXT_BITS-1:0] headers_ext;

    assign ch  = i_item.data_byte;
    assign sor = i_item.start_of_response;

    assign name_ch = (i_cfg.lower_case_names && ch >= CH_UP_A && ch <= CH_UP_Z) ?
                     ch + CASE_GAP : ch;

    always_comb begin
        c_phase       = sor ? PH_NAME : r_phase;
        c_line        = sor ? '0 : r_line;
        c_name_ne     = sor ? 1'b0 : r_name_ne;
        c_value_ne    = sor ? 1'b0 : r_value_ne;
        c_match_pos   = sor ? 3'd0 : r_match_pos;
        c_mismatch    = sor ? 1'b0 : r_mismatch;
        c_digits      = sor ? '0 : r_digits;
        c_status_acc  = sor ? '0 : r_status_acc;
        c_status_flag = sor ? 1'b0 : r_status_flag;
        c_headers     = sor ? '0 : r_headers;
        c_error       = sor ? ERR_NONE : r_error;
    end

    cghp_status_digits u_digits (
        .i_char (ch),
        .i_cur  (c_digits),
        .o_next (trk_digits)
    );

    always_comb begin
        n_phase       = c_phase;
        n_line        = c_line;
        n_name_ne     = c_name_ne;
        n_value_ne    = c_value_ne;
        n_match_pos   = c_match_pos;
        n_mismatch    = c_mismatch;
        n_digits      = c_digits;
        n_status_acc  = c_status_acc;
        n_status_flag = c_status_flag;
        n_headers     = c_headers;
        n_error       = c_error;
        kind          = KIND_NONE;
        emit          = 8'h00;
        unique case (c_phase)
            PH_ERROR: begin
                kind = KIND_ERROR;
            end
            PH_BODY: begin
                kind = KIND_BODY;
                emit = ch;
            end
            PH_CRWAIT: begin
                if (ch == CH_LF) begin
                    kind    = KIND_HDRS_END;
                    emit    = ch;
                    n_phase = PH_BODY;
                end else begin
                    kind    = KIND_ERROR;
                    n_error = ERR_CR_NO_LF;
                    n_phase = PH_ERROR;
                end
            end
            PH_NAME, PH_VALUE: begin
                if (c_line > i_cfg.max_line_len) begin
                    kind    = KIND_ERROR;
                    n_error = ERR_LINE_LONG;
                    n_phase = PH_ERROR;
                end else begin
                    if (c_line != LINE_MAX_COUNT) begin
                        n_line = c_line + 1'b1;
                    end
                    if (c_phase == PH_NAME) begin
                        if (ch == CH_COLON) begin
                            n_digits.open = !c_mismatch && (c_match_pos == STATUS_LEN);
                            n_phase       = PH_VALUE;
                        end else if (ch == CH_CR || ch == CH_LF) begin
                            if (c_name_ne) begin
                                kind    = KIND_ERROR;
                                n_error = ERR_NAME_BRK;
                                n_phase = PH_ERROR;
                            end else if (ch == CH_CR) begin
                                n_phase = PH_CRWAIT;
                            end else begin
                                kind    = KIND_HDRS_END;
                                emit    = ch;
                                n_phase = PH_BODY;
                            end
                        end else if (ch == CH_NUL) begin
                            kind    = KIND_ERROR;
                            n_error = ERR_NUL;
                            n_phase = PH_ERROR;
                        end else begin
                            if (!c_mismatch) begin
                                if (c_match_pos < STATUS_LEN &&
                                    (name_ch == status_char(c_match_pos) ||
                                     (c_match_pos == 3'd0 && name_ch == CH_UP_S))) begin
                                    n_match_pos = c_match_pos + 1'b1;
                                end else begin
                                    n_mismatch = 1'b1;
                                end
                            end
                            n_name_ne = 1'b1;
                            kind      = KIND_NAME;
                            emit      = name_ch;
                        end
                    end else begin
                        if (ch == CH_CR) begin
                            kind = KIND_NONE;
                        end else if (ch == CH_LF) begin
                            if (c_digits.seen) begin
                                n_status_acc  = c_digits.work;
                                n_status_flag = 1'b1;
                            end
                            if (c_headers != {COUNT_BITS{1'b1}}) begin
                                n_headers = c_headers + 1'b1;
                            end
                            kind        = KIND_HDR_DONE;
                            emit        = ch;
                            n_line      = '0;
                            n_name_ne   = 1'b0;
                            n_value_ne  = 1'b0;
                            n_match_pos = 3'd0;
                            n_mismatch  = 1'b0;
                            n_digits    = '0;
                            n_phase     = PH_NAME;
                        end else if (ch == CH_NUL) begin
                            kind    = KIND_ERROR;
                            n_error = ERR_NUL;
                            n_phase = PH_ERROR;
                        end else if (ch == CH_SPACE && !c_value_ne) begin
                            kind = KIND_NONE;
                        end else begin
                            n_digits   = trk_digits;
                            n_value_ne = 1'b1;
                            kind       = KIND_VALUE;
                            emit       = ch;
                        end
                    end
                end
            end
            default: begin
                kind = KIND_NONE;
            end
        endcase
    end

    assign headers_ext = COUNT_EXT_BITS'(n_headers);

    always_comb begin
        n_result.byte_kind    = kind;
        n_result.out_byte     = emit;
        n_result.error_code   = n_error;
        n_result.header_count = (headers_ext > COUNT_EXT_BITS'(8'hFF)) ? 8'hFF :
                                headers_ext[7:0];
        n_result.status_code  = n_status_acc;
        n_result.status_seen  = n_status_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_NAME;
            r_line        <= '0;
            r_name_ne     <= 1'b0;
            r_value_ne    <= 1'b0;
            r_match_pos   <= 3'd0;
            r_mismatch    <= 1'b0;
            r_digits      <= '0;
            r_status_acc  <= '0;
            r_status_flag <= 1'b0;
            r_headers     <= '0;
            r_error       <= ERR_NONE;
        end else if (i_advance) begin
            r_phase       <= n_phase;
            r_line        <= n_line;
            r_name_ne     <= n_name_ne;
            r_value_ne    <= n_value_ne;
            r_match_pos   <= n_match_pos;
            r_mismatch    <= n_mismatch;
            r_digits      <= n_digits;
            r_status_acc  <= n_status_acc;
            r_status_flag <= n_status_flag;
            r_headers     <= n_headers;
            r_error       <= n_error;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

FILE: design/cgi_header_line_parser_unit.sv
// Top level of the CGI response header line parser.
// The parser takes one byte of a CGI response per cycle while the output is not
// stalled, and returns one result word per byte. The byte waits in the input
// register while the parser logic handles it; the result word is then registered
// into the output register, where it waits until it is taken. The per-byte state
// update is combinational, so a new byte can follow in every cycle while the output
// is not stalled. A byte with start_of_response set clears all parser state before
// it is handled. Configuration registers lower_case_names (index 0) and max_line_len
// (index 1) are written through i_cfg_we and take effect for the next byte.
module cgi_header_line_parser_unit
    import cghp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_index,
    input  logic [LINE_BITS-1:0] i_cfg_data,
    cghp_in_if.sink              i_in,
    cghp_out_if.source           o_out
);

    t_cfg     r_cfg;
    logic     r_out_valid;
    logic     n_out_valid;
    logic     accept;
    logic     advance;
    logic     stage_valid;
    t_in_item in_item;
    t_in_item stage_item;
    t_result  result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lower_case_names <= 1'b1;
            r_cfg.max_line_len     <= LINE_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LOWER_CASE_NAMES: r_cfg.lower_case_names <= i_cfg_data[0];
                CFG_MAX_LINE_LEN:     r_cfg.max_line_len     <= i_cfg_data;
                default:              r_cfg                  <= r_cfg;
            endcase
        end
    end

    assign advance    = stage_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !stage_valid || advance;
    assign accept     = i_in.valid && i_in.ready;

    assign in_item.data_byte         = i_in.data_byte;
    assign in_item.start_of_response = i_in.start_of_response;

    cghp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_advance (advance),
        .i_item    (in_item),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    cghp_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (stage_item),
        .i_cfg     (r_cfg),
        .o_result  (result)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.byte_kind    = result.byte_kind;
    assign o_out.out_byte     = result.out_byte;
    assign o_out.error_code   = result.error_code;
    assign o_out.header_count = result.header_count;
    assign o_out.status_code  = result.status_code;
    assign o_out.status_seen  = result.status_seen;

`ifndef NO_ASSERTIONS
    a_error_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.byte_kind == KIND_ERROR) |-> (o_out.error_code != ERR_NONE))
        else $error("Error word without an error code.");

    a_quiet_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.byte_kind == KIND_NONE || o_out.byte_kind == KIND_ERROR))
        |-> (o_out.out_byte == 8'h00))
        else $error("Byte emitted on a word that carries none.");

    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out.valid)
        else $error("Parsed word did not reach the output register.");

    a_stall_holds_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stage_valid && !advance) |=> (stage_valid && $stable(stage_item)))
        else $error("Input register lost a word while stalled.");
`endif

endmodule

FILE: verif/cgi_header_line_parser_unit_test.sv
// Self-checking testbench for the CGI response header line parser.
`timescale 1ns / 1ps

module cgi_header_line_parser_unit_test;
    import cghp_pkg::*;

    localparam logic [7:0]  CH_PLUS     = 8'h2B;
    localparam logic [7:0]  CH_MINUS    = 8'h2D;
    localparam logic [7:0]  CH_LOW_A    = 8'h61;
    localparam logic [7:0]  CH_LOW_S    = 8'h73;
    localparam logic [47:0] STATUS_WORD = "status";
    localparam int          PHASE_ITEMS = 400;

    typedef enum logic [2:0] {
        PARSE_NAME,
        PARSE_VALUE,
        PARSE_CR_WAIT,
        PARSE_BODY,
        PARSE_ERROR
    } t_parse_phase;

    class parse_scoreboard;
        logic                   lower_names;
        logic [LINE_BITS-1:0]   line_limit;
        t_parse_phase           ph;
        logic [LINE_BITS-1:0]   line_cnt;
        logic                   name_any;
        logic                   value_any;
        logic [2:0]             match_pos;
        logic                   mismatch;
        logic                   digits_open;
        logic                   digit_seen;
        logic [STATUS_BITS-1:0] status_work;
        logic [STATUS_BITS-1:0] status_val;
        logic                   status_valid;
        logic [7:0]             hdr_count;
        logic [2:0]             err;
        t_result                expected_words[$];
        int                     fails;

        function new();
            lower_names = 1'b1;
            line_limit = LINE_LEN_RESET;
            fails = 0;
            clear_all();
        endfunction

        function void clear_line();
            line_cnt = '0;
            name_any = 1'b0;
            value_any = 1'b0;
            match_pos = '0;
            mismatch = 1'b0;
            digits_open = 1'b0;
            digit_seen = 1'b0;
            status_work = '0;
        endfunction

        function void clear_all();
            ph = PARSE_NAME;
            clear_line();
            status_val = '0;
            status_valid = 1'b0;
            hdr_count = '0;
            err = ERR_NONE;
        endfunction

        function logic [2:0] flag_error(input logic [2:0] code);
            err = code;
            ph = PARSE_ERROR;
            return KIND_ERROR;
        endfunction

        function void match_name(input logic [7:0] ch);
            if (mismatch)
                return;
            if (match_pos < STATUS_LEN &&
                (ch == STATUS_WORD[8*(5-match_pos) +: 8] || (match_pos == 0 && ch == CH_UP_S)))
                match_pos++;
            else
                mismatch = 1'b1;
        endfunction

        function void take_digit(input logic [7:0] ch);
            int v;
            if (!digits_open)
                return;
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
                v = status_work * 10 + (ch - CH_ZERO);
                status_work = (v > STATUS_MAX) ? STATUS_MAX : v[15:0];
                digit_seen = 1'b1;
            end else if (!digit_seen &&
                         (ch == CH_SPACE || ch == CH_TAB || ch == CH_VT || ch == CH_FF)) begin
                digits_open = 1'b1;
            end else begin
                digits_open = 1'b0;
            end
        endfunction

        function void note_byte(input t_in_item it);
            logic [7:0] ch;
            logic [2:0] kind;
            logic [7:0] emit;
            t_result    w;
            ch = it.data_byte;
            kind = KIND_NONE;
            emit = '0;
            if (it.start_of_response)
                clear_all();
            case (ph)
                PARSE_ERROR: kind = KIND_ERROR;
                PARSE_BODY: begin
                    kind = KIND_BODY;
                    emit = ch;
                end
                PARSE_CR_WAIT: begin
                    if (ch == CH_LF) begin
                        kind = KIND_HDRS_END;
                        emit = ch;
                        ph = PARSE_BODY;
                    end else begin
                        kind = flag_error(ERR_CR_NO_LF);
                    end
                end
                default: begin
                    if (line_cnt > line_limit) begin
                        kind = flag_error(ERR_LINE_LONG);
                    end else begin
                        if (line_cnt != LINE_MAX_COUNT)
                            line_cnt++;
                        if (ph == PARSE_NAME) begin
                            if (ch == CH_COLON) begin
                                digits_open = !mismatch && match_pos == STATUS_LEN;
                                ph = PARSE_VALUE;
                            end else if (ch == CH_CR || ch == CH_LF) begin
                                if (name_any) begin
                                    kind = flag_error(ERR_NAME_BRK);
                                end else if (ch == CH_CR) begin
                                    ph = PARSE_CR_WAIT;
                                end else begin
                                    kind = KIND_HDRS_END;
                                    emit = ch;
                                    ph = PARSE_BODY;
                                end
                            end else if (ch == CH_NUL) begin
                                kind = flag_error(ERR_NUL);
                            end else begin
                                if (lower_names && ch >= CH_UP_A && ch <= CH_UP_Z)
                                    ch = ch + CASE_GAP;
                                match_name(ch);
                                name_any = 1'b1;
                                kind = KIND_NAME;
                                emit = ch;
                            end
                        end else begin
                            if (ch == CH_LF) begin
                                if (digit_seen) begin
                                    status_val = status_work;
                                    status_valid = 1'b1;
                                end
                                if (hdr_count != 8'hFF)
                                    hdr_count++;
                                kind = KIND_HDR_DONE;
                                emit = ch;
                                clear_line();
                                ph = PARSE_NAME;
                            end else if (ch == CH_NUL) begin
                                kind = flag_error(ERR_NUL);
                            end else if (ch != CH_CR && (ch != CH_SPACE || value_any)) begin
                                take_digit(ch);
                                value_any = 1'b1;
                                kind = KIND_VALUE;
                                emit = ch;
                            end
                        end
                    end
                end
            endcase
            w.byte_kind = kind;
            w.out_byte = emit;
            w.error_code = err;
            w.header_count = hdr_count;
            w.status_code = status_val;
            w.status_seen = status_valid;
            expected_words = {expected_words, w};
        endfunction

        task report(input string msg);
            if (fails < 100)
                $display("%0t ns: mismatch: %s", $time, msg);
            fails++;
        endtask

        task check_word(input t_result got);
            t_result want;
            if (expected_words.size() == 0) begin
                report($sformatf("word with no byte pending, kind %0d", got.byte_kind));
                return;
            end
            want = expected_words.pop_front();
            if (got.byte_kind !== want.byte_kind)
                report($sformatf("byte_kind %0d, want %0d", got.byte_kind, want.byte_kind));
            if (got.out_byte !== want.out_byte)
                report($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
            if (got.error_code !== want.error_code)
                report($sformatf("error_code %0d, want %0d", got.error_code, want.error_code));
            if (got.header_count !== want.header_count)
                report($sformatf("header_count %0d, want %0d",
                                 got.header_count, want.header_count));
            if (got.status_code !== want.status_code)
                report($sformatf("status_code %0d, want %0d",
                                 got.status_code, want.status_code));
            if (got.status_seen !== want.status_seen)
                report($sformatf("status_seen %0d, want %0d",
                                 got.status_seen, want.status_seen));
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [0:0]           i_cfg_index;
    logic [LINE_BITS-1:0] i_cfg_data;

    cghp_in_if  byte_ch();
    cghp_out_if word_ch();

    parse_scoreboard tracker = new();

    int send_idle_pct = 0;
    int stall_pct = 0;
    int sent = 0;
    bit new_resp = 1'b0;

    cgi_header_line_parser_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in       (byte_ch),
        .o_out      (word_ch)
    );

    always #6 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        word_ch.ready = ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        t_in_item it;
        t_result  got;
        if (i_rst_n === 1'b1) begin
            if (byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1) begin
                it.data_byte = byte_ch.data_byte;
                it.start_of_response = byte_ch.start_of_response;
                tracker.note_byte(it);
            end
            if (word_ch.valid === 1'b1 && word_ch.ready === 1'b1) begin
                got.byte_kind = word_ch.byte_kind;
                got.out_byte = word_ch.out_byte;
                got.error_code = word_ch.error_code;
                got.header_count = word_ch.header_count;
                got.status_code = word_ch.status_code;
                got.status_seen = word_ch.status_seen;
                tracker.check_word(got);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            byte_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        byte_ch.valid = 1'b1;
        byte_ch.data_byte = b;
        byte_ch.start_of_response = new_resp;
        new_resp = 1'b0;
        @(posedge i_clk);
        while (byte_ch.ready !== 1'b1)
            @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
            send_byte(s[k]);
    endtask

    task automatic drain();
        byte_ch.valid = 1'b0;
        while (tracker.expected_words.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_config(input logic lower, input logic [LINE_BITS-1:0] limit);
        i_cfg_we = 1'b1;
        i_cfg_index = CFG_LOWER_CASE_NAMES;
        i_cfg_data = {{(LINE_BITS-1){1'b0}}, lower};
        @(negedge i_clk);
        i_cfg_index = CFG_MAX_LINE_LEN;
        i_cfg_data = limit;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        tracker.lower_names = lower;
        tracker.line_limit = limit;
    endtask

    function automatic logic [7:0] name_char();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0: c = CH_UP_A + 8'($urandom_range(0, 25));
            1: c = CH_LOW_A + 8'($urandom_range(0, 25));
            default: begin
                c = 8'($urandom_range(1, 255));
                if (c == CH_COLON || c == CH_CR || c == CH_LF)
                    c = CH_UP_S;
            end
        endcase
        return c;
    endfunction

    function automatic logic [7:0] value_char();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0: c = CH_SPACE;
            1: c = CH_CR;
            2: c = ($urandom_range(0, 1) != 0) ? CH_PLUS : CH_MINUS;
            3: c = CH_ZERO + 8'($urandom_range(0, 9));
            default: begin
                c = 8'($urandom_range(1, 255));
                if (c == CH_LF)
                    c = CH_TAB;
            end
        endcase
        return c;
    endfunction

    function automatic logic [7:0] blank_char();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0: c = CH_SPACE;
            1: c = CH_TAB;
            2: c = CH_VT;
            default: c = CH_FF;
        endcase
        return c;
    endfunction

    task automatic random_header();
        int n;
        case ($urandom_range(0, 11))
            0, 1, 2: send_text("status");
            3: send_text("Status");
            4: send_text("STATUS");
            5: send_text("stat");
            6: send_text("statuses");
            7: send_text("sTatus");
            8: ;
            default: begin
                n = $urandom_range(1, 8);
                repeat (n) send_byte(name_char());
            end
        endcase
        if ($urandom_range(0, 39) == 0) begin
            case ($urandom_range(0, 2))
                0: send_byte(CH_CR);
                1: send_byte(CH_LF);
                default: send_byte(CH_NUL);
            endcase
        end
        send_byte(CH_COLON);
        n = $urandom_range(0, 3);
        repeat (n) send_byte(CH_SPACE);
        if ($urandom_range(0, 1) != 0) begin
            n = $urandom_range(0, 2);
            repeat (n) send_byte(blank_char());
            if ($urandom_range(0, 9) == 0)
                send_byte(CH_PLUS);
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 9) : $urandom_range(0, 4);
            repeat (n) send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        n = $urandom_range(0, 6);
        repeat (n) send_byte(value_char());
        if ($urandom_range(0, 39) == 0)
            send_byte(CH_NUL);
        if ($urandom_range(0, 2) != 0)
            send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    task automatic random_response();
        int n;
        new_resp = 1'b1;
        n = $urandom_range(0, 6);
        repeat (n) random_header();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                send_byte(CH_CR);
                send_byte(CH_LF);
            end
            5, 6, 7, 8: send_byte(CH_LF);
            default: begin
                send_byte(CH_CR);
                send_byte(8'($urandom_range(0, 255)));
            end
        endcase
        n = $urandom_range(0, 12);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic noise_response();
        int n;
        logic [7:0] c;
        new_resp = ($urandom_range(0, 1) != 0);
        n = $urandom_range(1, 24);
        repeat (n) begin
            case ($urandom_range(0, 26))
                0: c = CH_NUL;
                1: c = CH_CR;
                2: c = CH_LF;
                3: c = CH_COLON;
                4: c = CH_SPACE;
                5: c = CH_UP_S;
                6: c = CH_LOW_S;
                7: c = CH_ZERO;
                8: c = CH_NINE;
                default: c = 8'($urandom_range(0, 255));
            endcase
            send_byte(c);
        end
    endtask

    task automatic long_line(input int n);
        new_resp = 1'b1;
        send_byte(name_char());
        send_byte(CH_COLON);
        repeat (n) send_byte(value_char());
        send_byte(CH_LF);
    endtask

    task automatic many_headers(input int n);
        new_resp = 1'b1;
        repeat (n) begin
            send_byte(CH_COLON);
            send_byte(CH_LF);
        end
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(8'hFF);
    endtask

    initial begin
        #20_000_000;
        $display("cgi_header_line_parser_unit_test: FAIL");
        $finish;
    end

    initial begin
        int                   p;
        int                   phase_start;
        logic                 lower;
        logic [LINE_BITS-1:0] limit;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_LOWER_CASE_NAMES;
        i_cfg_data = '0;
        byte_ch.valid = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.start_of_response = 1'b0;
        word_ch.ready = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed words under the reset configuration.
        new_resp = 1'b1;
        send_text("Status: 2");
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(8'hFF);
        new_resp = 1'b1;
        send_byte(CH_UP_A);
        send_byte(CH_CR);
        send_byte(CH_NUL);
        new_resp = 1'b1;
        send_byte(CH_NUL);
        new_resp = 1'b1;
        send_byte(CH_CR);
        send_byte(8'hFF);
        new_resp = 1'b1;
        send_byte(CH_COLON);
        send_byte(CH_TAB);
        send_byte(CH_LF);
        send_byte(CH_LF);

        for (p = 0; p < 5; p++) begin
            drain();
            case (p)
                0: begin
                    lower = 1'b1;
                    limit = LINE_LEN_RESET;
                end
                1: begin
                    lower = 1'b0;
                    limit = LINE_BITS'(1);
                end
                2: begin
                    lower = 1'b1;
                    limit = LINE_MAX_COUNT;
                end
                3: begin
                    lower = 1'b0;
                    limit = LINE_BITS'($urandom_range(8, 40));
                end
                default: begin
                    lower = 1'b1;
                    limit = LINE_BITS'($urandom_range(20, 120));
                end
            endcase
            set_config(lower, limit);
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 52;
                    stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct = 52;
                end
                default: begin
                    send_idle_pct = 7;
                    stall_pct = 7;
                end
            endcase
            phase_start = sent;
            if (p == 1)
                many_headers(260);
            else
                long_line((p == 2) ? 520 : int'(limit) + 3);
            while (sent - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(0, 6) == 0)
                    noise_response();
                else
                    random_response();
            end
        end

        drain();
        repeat (8) @(negedge i_clk);
        if (tracker.fails == 0 && tracker.expected_words.size() == 0)
            $display("cgi_header_line_parser_unit_test: PASS");
        else
            $display("cgi_header_line_parser_unit_test: FAIL");
        $finish;
    end

endmodule
